// ----- hw/rtl/stpc_pkg.sv -----
package stpc_pkg;

    localparam int KIND_MAX    = 7;
    localparam int MASK_SLOTS  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int DATA_W      = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_ENABLE = 2'd0,
        CFG_PRINT_KIND   = 2'd1,
        CFG_START_VALUE  = 2'd2
    } t_cfg_idx;

    localparam logic       REC_FOUND  = 1'b0;
    localparam logic       REC_REPORT = 1'b1;
    localparam logic [2:0] PRINT_OFF  = 3'd0;
    localparam logic [DATA_W-1:0] WHEEL_STEP = 64'd30;

    typedef logic [3:0] t_cnt;
    typedef logic [7:0] t_mask_row [MASK_SLOTS];

    // One queued byte: base number, print matches and per-kind counts.
    typedef struct packed {
        logic [DATA_W-1:0]  base;
        logic [7:0]         match;
        logic [2:0]         pk;
        t_cnt [KIND_MAX-1:0] counts;
        logic               eos;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam t_mask_row MASK_TAB [KIND_MAX] = '{
        '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80},
        '{8'h06, 8'h18, 8'hc0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h07, 8'h0e, 8'h1c, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h1f, 8'h3e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hfe, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] KIND_LEN [KIND_MAX] = '{
        4'd8, 4'd3, 4'd4, 4'd1, 4'd2, 4'd1, 4'd1
    };

    localparam logic [4:0] BIT_OFS [8] = '{
        5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23, 5'd29, 5'd31
    };

    // Flag each mask of the kind that is wholly set in the byte.
    function automatic logic [7:0] kind_hits(input logic [2:0] kind, input logic [7:0] b);
        logic [7:0] hit;
        hit = '0;
        if (kind < 3'(KIND_MAX)) begin
            for (int j = 0; j < MASK_SLOTS; j++) begin
                hit[j] = (4'(j) < KIND_LEN[kind]) &&
                         ((b & MASK_TAB[kind][j]) == MASK_TAB[kind][j]);
            end
        end
        return hit;
    endfunction

    function automatic logic [2:0] lowest_bit(input logic [7:0] m);
        logic [2:0] idx;
        logic       seen;
        idx  = '0;
        seen = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (m[i] && !seen) begin
                idx  = 3'(i);
                seen = 1'b1;
            end
        end
        return idx;
    endfunction

endpackage

// ----- hw/rtl/stpc_front.sv -----
module stpc_front #(
    parameter int NUM_KINDS = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_sieve_byte,
    input  logic                 i_end_of_segment,
    input  logic [2:0]           i_print_kind,
    input  logic                 i_start_we,
    input  logic [63:0]          i_start_value,
    input  stpc_pkg::t_q_status  i_q,
    output logic                 o_push,
    output stpc_pkg::t_entry     o_entry
);
    import stpc_pkg::*;

    logic [DATA_W-1:0] r_base;
    logic [2:0]        pk;
    logic              print_on;

    assign o_in_stall = i_q.full;
    assign o_push     = i_in_valid && !i_q.full;

    assign pk       = i_print_kind - 3'd1;
    assign print_on = (i_print_kind != PRINT_OFF) && (pk < 3'(NUM_KINDS));

    always_comb begin
        o_entry.base  = r_base;
        o_entry.pk    = pk;
        o_entry.eos   = i_end_of_segment;
        o_entry.match = print_on ? kind_hits(pk, i_sieve_byte) : 8'd0;
        for (int k = 0; k < KIND_MAX; k++) begin
            o_entry.counts[k] = 4'($countones(kind_hits(3'(k), i_sieve_byte)));
        end
    end

    // Load the start value on a config write, else advance the base by one wheel turn per accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_start_we) begin
            r_base <= i_start_value;
        end else if (o_push) begin
            r_base <= r_base + WHEEL_STEP;
        end
    end

endmodule

// ----- hw/rtl/stpc_fifo.sv -----
module stpc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  stpc_pkg::t_entry     i_entry,
    input  logic                 i_pop,
    output stpc_pkg::t_entry     o_entry,
    output stpc_pkg::t_q_status  o_status
);
    import stpc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_entry        = r_mem[r_rptr];
    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/stpc_back.sv -----
module stpc_back #(
    parameter int NUM_KINDS = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [6:0]           i_count_enable,
    input  stpc_pkg::t_q_status  i_q,
    input  stpc_pkg::t_entry     i_entry,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_record_type,
    output logic [2:0]           o_pattern_kind,
    output logic [63:0]          o_value,
    output logic [7:0]           o_member_mask,
    output logic                 o_last_result
);
    import stpc_pkg::*;

    localparam int KW = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;

    logic [DATA_W-1:0]    r_totals [NUM_KINDS];
    logic [7:0]           r_match;
    logic [NUM_KINDS-1:0] r_rep;
    logic [DATA_W-1:0]    r_base;
    logic [2:0]           r_pk;

    logic                 r_out_valid;
    logic                 r_rec;
    logic [2:0]           r_kind;
    logic [DATA_W-1:0]    r_value;
    logic [7:0]           r_mask;
    logic                 r_last;

    logic                 pending;
    logic                 emit;
    logic                 found;
    logic [2:0]           sel_j;
    logic [2:0]           sel_k;
    logic [7:0]           sel_mask;
    logic [7:0]           n_match;
    logic [NUM_KINDS-1:0] n_rep;
    logic                 n_rec;
    logic [2:0]           n_kind;
    logic [DATA_W-1:0]    n_value;
    logic [7:0]           n_mask;

    assign pending = (r_match != '0) || (r_rep != '0);
    assign o_pop   = !pending && !i_q.empty;
    assign emit    = pending && (!r_out_valid || !i_out_stall);

    always_comb begin
        found    = (r_match != '0);
        sel_j    = lowest_bit(r_match);
        sel_k    = lowest_bit(8'(r_rep));
        sel_mask = MASK_TAB[r_pk][sel_j];
        n_match  = r_match;
        n_rep    = r_rep;
        if (found) begin
            n_match = r_match & ~(8'd1 << sel_j);
            n_rec   = REC_FOUND;
            n_kind  = r_pk;
            n_value = r_base + DATA_W'(BIT_OFS[lowest_bit(sel_mask)]);
            n_mask  = sel_mask;
        end else begin
            n_rep   = r_rep & ~(NUM_KINDS'(1) << sel_k);
            n_rec   = REC_REPORT;
            n_kind  = sel_k;
            n_value = r_totals[sel_k[KW-1:0]];
            n_mask  = 8'd0;
        end
    end

    // Load a queued byte (fold enabled counts into totals, arm records); clear each record as it is emitted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
            r_rep   <= '0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_totals[k] <= '0;
            end
        end else if (o_pop) begin
            r_match <= i_entry.match;
            r_rep   <= i_entry.eos ? i_count_enable[NUM_KINDS-1:0] : '0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                if (i_count_enable[k]) begin
                    r_totals[k] <= r_totals[k] + DATA_W'(i_entry.counts[k]);
                end
            end
        end else if (emit) begin
            r_match <= n_match;
            r_rep   <= n_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_base <= i_entry.base;
            r_pk   <= i_entry.pk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_rec   <= n_rec;
            r_kind  <= n_kind;
            r_value <= n_value;
            r_mask  <= n_mask;
            r_last  <= (n_match == '0) && (n_rep == '0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_record_type  = r_rec;
    assign o_pattern_kind = r_kind;
    assign o_value        = r_value;
    assign o_member_mask  = r_mask;
    assign o_last_result  = r_last;

endmodule

// ----- hw/rtl/sieve_byte_prime_tuplet_counter.sv -----
// Flow: an accepted byte is written into the queue; the back end pops it into
//   its record state once none are pending, then emits through the output register.
// Throughput: the back end pops a byte only when it has no records pending,
//   then sends its results (up to 15) one at a time through the single output
//   register while the receiver does not stall. Bytes with no result go at 1 per cycle.
// Reset: synchronous, active low; clears totals, base, config and queue.
module sieve_byte_prime_tuplet_counter #(
    parameter int NUM_KINDS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_sieve_byte,
    input  logic        i_end_of_segment,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_record_type,
    output logic [2:0]  o_pattern_kind,
    output logic [63:0] o_value,
    output logic [7:0]  o_member_mask,
    output logic        o_last_result,
    // config write port
    input  logic        i_cfg_we,
    input  logic [stpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import stpc_pkg::*;

    // Config registers. start_value lives in the front end as the running base.
    logic [6:0] r_count_enable;
    logic [2:0] r_print_kind;
    logic       start_we;

    t_entry     w_push_entry;
    t_entry     w_pop_entry;
    t_q_status  w_q;
    logic       w_push;
    logic       w_pop;

    assign start_we = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_START_VALUE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_enable <= '0;
            r_print_kind   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_COUNT_ENABLE: r_count_enable <= i_cfg_data[6:0];
                CFG_PRINT_KIND:   r_print_kind   <= i_cfg_data[2:0];
                default: ;  // start value handled by the front end; drop others
            endcase
        end
    end

    // Front: accept bytes, classify masks, stamp the base number.
    stpc_front #(
        .NUM_KINDS (NUM_KINDS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sieve_byte     (i_sieve_byte),
        .i_end_of_segment (i_end_of_segment),
        .i_print_kind     (r_print_kind),
        .i_start_we       (start_we),
        .i_start_value    (i_cfg_data),
        .i_q              (w_q),
        .o_push           (w_push),
        .o_entry          (w_push_entry)
    );

    // Short queue so the byte side keeps moving while records drain.
    stpc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_entry  (w_pop_entry),
        .o_status (w_q)
    );

    // Back: accumulate totals, serialize found records then count reports.
    stpc_back #(
        .NUM_KINDS (NUM_KINDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_count_enable (r_count_enable),
        .i_q            (w_q),
        .i_entry        (w_pop_entry),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_record_type  (o_record_type),
        .o_pattern_kind (o_pattern_kind),
        .o_value        (o_value),
        .o_member_mask  (o_member_mask),
        .o_last_result  (o_last_result)
    );

    // Never pop an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q.empty)
        else $error("pop from empty queue");

    // A report record carries no member mask.
    a_report_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_record_type == REC_REPORT)) |-> (o_member_mask == 8'd0))
        else $error("report record with nonzero mask");

    // A found record always names at least one member.
    a_found_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_record_type == REC_FOUND)) |-> (o_member_mask != 8'd0))
        else $error("found record with empty mask");

    // A full queue held over a cycle with no pop must still be full.
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q.full && !w_pop) |=> w_q.full)
        else $error("queue lost an entry");

endmodule

// ----- dv/sieve_byte_prime_tuplet_counter_test.sv -----
module sieve_byte_prime_tuplet_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import stpc_pkg::*;

    localparam int          NUM_KINDS    = 7;
    localparam int          SETTLE       = 16;    // cycles to let bytes with no result retire
    localparam int          QUIET_LIMIT  = 2000;  // cycles without any handshake
    localparam int          HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam logic [63:0] BYTE_SPAN    = 64'd30;
    // Index that maps to no register; the block must ignore the write.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    // Pattern masks per kind: primes, twins, triplets, quadruplets,
    // quintuplets, sextuplets, septuplets.
    localparam logic [7:0] TUPLET_MASK [20] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
        8'h06, 8'h18, 8'hc0,
        8'h07, 8'h0e, 8'h1c, 8'h38,
        8'h1e,
        8'h1f, 8'h3e,
        8'h3f,
        8'hfe
    };
    localparam int KIND_FIRST [7] = '{0, 8, 11, 15, 16, 18, 19};
    localparam int KIND_SIZE  [7] = '{8, 3, 4, 1, 2, 1, 1};
    // Distance of each byte bit's candidate from the byte base.
    localparam logic [63:0] MEMBER_OFS [8] = '{
        64'd7, 64'd11, 64'd13, 64'd17, 64'd19, 64'd23, 64'd29, 64'd31
    };

    typedef struct packed {
        logic        rec_type;
        logic [2:0]  kind;
        logic [63:0] value;
        logic [7:0]  member_mask;
        logic        is_last;
    } t_record;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_sieve_byte     = '0;
    logic        i_end_of_segment = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic        o_record_type;
    logic [2:0]  o_pattern_kind;
    logic [63:0] o_value;
    logic [7:0]  o_member_mask;
    logic        o_last_result;
    logic        i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [63:0] i_cfg_data       = '0;

    sieve_byte_prime_tuplet_counter #(
        .NUM_KINDS(NUM_KINDS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sieve_byte     (i_sieve_byte),
        .i_end_of_segment (i_end_of_segment),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_record_type    (o_record_type),
        .o_pattern_kind   (o_pattern_kind),
        .o_value          (o_value),
        .o_member_mask    (o_member_mask),
        .o_last_result    (o_last_result),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // Shadow of the block's state and registers.
    logic [63:0] kind_total [NUM_KINDS];
    logic [63:0] byte_pos;
    logic [6:0]  enable_reg;
    logic [2:0]  print_reg;
    logic [63:0] start_reg;

    t_record pending_records [$];   // records still owed by the block, oldest first
    int      fail_count = 0;
    bit      idle_on    = 1'b1;     // random gaps on both sides
    bit      hold_req   = 1'b0;     // ask the receiver for one long hold-off

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Work out every record one byte causes and advance the shadow state.
    function automatic void predict_byte(input logic [7:0] b, input logic eos);
        t_record     batch [$];
        t_record     rec;
        logic [63:0] base;
        logic [7:0]  m;
        int          pk;
        int          lo;
        base = start_reg + byte_pos * BYTE_SPAN;

        // Accumulate per-kind match counts into the enabled totals.
        for (int k = 0; k < NUM_KINDS; k++) begin
            logic [63:0] hits;
            hits = '0;
            for (int j = 0; j < KIND_SIZE[k]; j++) begin
                m = TUPLET_MASK[KIND_FIRST[k] + j];
                if ((b & m) == m) hits++;
            end
            if (enable_reg[k]) kind_total[k] += hits;
        end

        // Found records of the printed kind, in mask-table order.
        if (print_reg != PRINT_OFF && int'(print_reg) <= NUM_KINDS) begin
            pk = int'(print_reg) - 1;
            for (int j = 0; j < KIND_SIZE[pk]; j++) begin
                m = TUPLET_MASK[KIND_FIRST[pk] + j];
                if ((b & m) == m) begin
                    lo = 0;
                    while (!m[lo]) lo++;
                    rec.rec_type    = REC_FOUND;
                    rec.kind        = 3'(pk);
                    rec.value       = base + MEMBER_OFS[lo];
                    rec.member_mask = m;
                    rec.is_last     = 1'b0;
                    batch.push_back(rec);
                end
            end
        end

        // Running totals at the end of a segment, ascending kind.
        if (eos) begin
            for (int k = 0; k < NUM_KINDS; k++) begin
                if (enable_reg[k]) begin
                    rec.rec_type    = REC_REPORT;
                    rec.kind        = 3'(k);
                    rec.value       = kind_total[k];
                    rec.member_mask = '0;
                    rec.is_last     = 1'b0;
                    batch.push_back(rec);
                end
            end
        end

        if (batch.size() > 0) batch[batch.size() - 1].is_last = 1'b1;
        foreach (batch[i]) pending_records.push_back(batch[i]);
        byte_pos++;
    endfunction

    // Offer one byte, hold it until taken, then predict. Valid stays high on
    // return so a following byte can go back to back.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_sieve_byte     <= b;
        i_end_of_segment <= eos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_byte(b, eos);
    endtask

    // Drop valid, wait for every owed record, then let silent bytes retire.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_COUNT_ENABLE: enable_reg = data[6:0];
            CFG_PRINT_KIND:   print_reg  = data[2:0];
            CFG_START_VALUE: begin
                start_reg = data;
                byte_pos  = '0;   // a new base restarts the byte count, totals stay
            end
            default: ;
        endcase
    endtask

    // Bias toward dense bytes so long tuplets show up often.
    function automatic logic [7:0] dense_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = 8'hff ^ (8'($urandom_range(0, 1)) << $urandom_range(0, 7));
            1:       b = TUPLET_MASK[$urandom_range(8, 19)] | 8'($urandom & $urandom);
            2:       b = 8'($urandom);
            default: b = 8'($urandom | $urandom);
        endcase
        return b;
    endfunction

    task automatic send_random_bytes(input int count);
        for (int i = 0; i < count; i++) begin
            send_byte(dense_byte(), $urandom_range(0, 3) == 0);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Registers are all zero out of reset: nothing counts, nothing prints.
    task automatic test_reset_defaults();
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    // Print each kind in turn on a full byte and on its own first mask.
    task automatic test_each_kind_printed();
        write_reg(CFG_COUNT_ENABLE, 64'h7f);
        for (int k = 0; k < NUM_KINDS; k++) begin
            write_reg(CFG_PRINT_KIND, 64'(k + 1));
            send_byte(8'hff, 1'b0);
            send_byte(TUPLET_MASK[KIND_FIRST[k]], k == NUM_KINDS - 1);
        end
        write_reg(CFG_PRINT_KIND, 64'(PRINT_OFF));
        send_byte(8'hff, 1'b1);
    endtask

    // Base near the top of the range: candidate values and bases wrap.
    task automatic test_wrap_base();
        write_reg(CFG_COUNT_ENABLE, 64'h0);
        write_reg(CFG_PRINT_KIND, 64'd1);
        write_reg(CFG_START_VALUE, 64'hffff_ffff_ffff_ffff);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        write_reg(CFG_START_VALUE, 64'hffff_ffff_ffff_ffe0);
        send_byte(8'h81, 1'b1);
    endtask

    // A write to the unused index must leave every register as it was.
    task automatic test_ignored_index();
        write_reg(CFG_COUNT_ENABLE, 64'h55);
        write_reg(CFG_IDX_UNUSED, 64'hffff_ffff_ffff_ffff);
        send_byte(8'hff, 1'b1);
    endtask

    task automatic test_random_counting();
        write_reg(CFG_PRINT_KIND, 64'(PRINT_OFF));
        write_reg(CFG_START_VALUE, {$urandom, $urandom});
        write_reg(CFG_COUNT_ENABLE, 64'($urandom_range(1, 127)));
        send_random_bytes(50);
        write_reg(CFG_COUNT_ENABLE, 64'h7f);
        send_random_bytes(10);
    endtask

    task automatic test_random_printing();
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(CFG_COUNT_ENABLE, 64'($urandom));
            // Make sure the longest and shortest patterns get their turn.
            write_reg(CFG_PRINT_KIND, phase == 0 ? 64'd7 : phase == 1 ? 64'd1 :
                                      64'($urandom_range(1, 7)));
            if (phase == 2) write_reg(CFG_START_VALUE, {$urandom, $urandom});
            send_random_bytes(40);
        end
    endtask

    // Receiver holds off for a long stretch while bytes keep coming, so the
    // queue fills and the input stalls.
    task automatic test_receiver_hold();
        write_reg(CFG_PRINT_KIND, 64'd1);
        hold_req = 1'b1;
        while (!i_out_stall || hold_req) @(posedge i_clk);
        send_random_bytes(20);
    endtask

    // Sender stops until every owed record is out, then resumes.
    task automatic test_sender_pause();
        send_random_bytes(10);
        i_in_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        send_random_bytes(10);
    endtask

    // Last stretch: no gaps, no stalls, full rate.
    task automatic test_steady_stream();
        write_reg(CFG_COUNT_ENABLE, 64'h7f);
        write_reg(CFG_PRINT_KIND, 64'($urandom_range(1, 7)));
        idle_on = 1'b0;
        send_random_bytes(40);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        foreach (kind_total[k]) kind_total[k] = '0;
        byte_pos   = '0;
        enable_reg = '0;
        print_reg  = PRINT_OFF;
        start_reg  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_each_kind_printed();
        test_wrap_base();
        test_ignored_index();
        test_random_counting();
        test_random_printing();
        test_receiver_hold();
        test_sender_pause();
        test_steady_stream();

        wait_drained();
        if (pending_records.size() != 0)
            report_mismatch($sformatf("%0d records never arrived", pending_records.size()));
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver stall: random bursts, free-running stretches, and one long
    // hold-off on request. Each pass drives the stall once and advances.
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted record with the oldest one owed.
    always @(posedge i_clk) begin
        t_record got;
        t_record want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_record_type, o_pattern_kind, o_value, o_member_mask, o_last_result};
            if (pending_records.size() == 0) begin
                report_mismatch($sformatf("unexpected record type %0d kind %0d value %h",
                                          got.rec_type, got.kind, got.value));
            end else begin
                want = pending_records.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "got t%0d k%0d v%h m%h l%0d, want t%0d k%0d v%h m%h l%0d",
                        got.rec_type, got.kind, got.value, got.member_mask, got.is_last,
                        want.rec_type, want.kind, want.value, want.member_mask,
                        want.is_last));
            end
        end
    end

    // Stop a hung run: count cycles in which no handshake happens at all.
    always @(posedge i_clk) begin
        int quiet;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
